### rtl/core/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// shared sizes, pipeline structs, decay table entries and saturation helpers
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int CHANNELS    = 1024;
  localparam int STATE_SLOTS = 16;
  localparam int STATE_DEPTH = CHANNELS * STATE_SLOTS;
  localparam int IDX_W       = $clog2(STATE_DEPTH);

  localparam int CH_W    = 10;
  localparam int SLOT_W  = 4;
  localparam int U_W     = 16;
  localparam int A_W     = 12;
  localparam int WGT_W   = 16;
  localparam int STATE_W = 32;
  localparam int SUM_W   = 48;
  localparam int Z_W     = 40;

  localparam int DECAY_W     = 16;
  localparam int DECAY_DEPTH = 2 ** A_W;
  localparam int DECAY_HALF  = DECAY_DEPTH / 2;
  localparam int A_FRAC      = 8;

  // q4.8 step and ln of the q0.16 scale, so the sigmoid needs no division
  localparam real A_STEP   = 1.0 / real'(2 ** A_FRAC);
  localparam real DECAY_LN = real'(DECAY_W) * $ln(2.0);

  typedef logic [DECAY_W-1:0] decay_table_t [DECAY_DEPTH];

  // per-request control that travels with the data down the pipeline
  typedef struct packed {
    logic            valid;
    logic            last;
    logic            ok;
    logic [CH_W-1:0] channel;
    logic [IDX_W-1:0] idx;
  } item_ctl_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [STATE_W-1:0] data;
  } state_wr_t;

  // sigmoid in q0.16, entry index is a_raw in two's complement
  function automatic logic [DECAY_W-1:0] decay_entry(input int i);
    real x;
    real r;
    int  v;
    x = (i < DECAY_HALF) ? real'(i) : real'(i - DECAY_DEPTH);
    r = $exp(DECAY_LN - $ln(1.0 + $exp(-x * A_STEP)));
    v = $rtoi(r + 0.5);
    if (v > (2 ** DECAY_W) - 1) begin
      v = (2 ** DECAY_W) - 1;
    end
    return DECAY_W'(v);
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [33:0] x);
    logic signed [STATE_W-1:0] r;
    if (!x[33] && (|x[32:31])) begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end else if (x[33] && !(&x[32:31])) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = x[STATE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
    logic signed [SUM_W-1:0] r;
    if (x[SUM_W] != x[SUM_W-1]) begin
      r = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = x[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W:0] x);
    logic signed [Z_W-1:0] r;
    if (!x[SUM_W] && (|x[SUM_W-1:Z_W-1])) begin
      r = {1'b0, {(Z_W-1){1'b1}}};
    end else if (x[SUM_W] && !(&x[SUM_W-1:Z_W-1])) begin
      r = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      r = x[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/dss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/dss_decay_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_decay_rom
// sigmoid decay lookup, q0.16, registered read
// ----------------------------------------------------------------------------
module dss_decay_rom (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [dss_pkg::A_W-1:0]      rd_addr,
  output logic [dss_pkg::DECAY_W-1:0]  rd_data
);
  import dss_pkg::*;

  decay_table_t decay_table;

  // rom contents, fixed at load time
  initial begin
    for (int i = 0; i < DECAY_DEPTH; i++) begin
      decay_table[i] = decay_entry(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= decay_table[rd_addr];
    end
  end

endmodule

### rtl/core/dss_state_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_state_update
// decay and input products, saturated new state and its write back
// ----------------------------------------------------------------------------
module dss_state_update (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  dss_pkg::item_ctl_t                 p1_ctl,
  input  logic [dss_pkg::STATE_W-1:0]        old_raw,
  input  logic [dss_pkg::DECAY_W-1:0]        decay,
  input  logic signed [dss_pkg::U_W-1:0]     p1_u,
  input  logic signed [dss_pkg::WGT_W-1:0]   p1_b,
  input  logic signed [dss_pkg::WGT_W-1:0]   p1_c,
  input  logic signed [dss_pkg::WGT_W-1:0]   p1_d,
  output dss_pkg::item_ctl_t                 p2_ctl,
  output logic signed [dss_pkg::STATE_W-1:0] p2_ns,
  output logic signed [dss_pkg::U_W-1:0]     p2_u,
  output logic signed [dss_pkg::WGT_W-1:0]   p2_c,
  output logic signed [dss_pkg::WGT_W-1:0]   p2_d,
  output dss_pkg::state_wr_t                 state_wr
);
  import dss_pkg::*;

  logic signed [STATE_W-1:0]   old_state;
  logic signed [DECAY_W+STATE_W:0] prod_a;
  logic signed [31:0]          prod_bu;
  logic signed [DECAY_W+STATE_W:0] p2_prod_a;
  logic signed [31:0]          p2_prod_bu;
  logic signed [32:0]          a_shift;
  logic signed [33:0]          ns_wide;

  // out-of-range elements start from zero
  assign old_state = p1_ctl.ok ? $signed(old_raw) : '0;
  assign prod_a    = $signed({1'b0, decay}) * old_state;
  assign prod_bu   = p1_b * p1_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_ctl.valid <= 1'b0;
    end else if (adv) begin
      p2_ctl.valid <= p1_ctl.valid;
    end
    if (adv) begin
      p2_ctl.last    <= p1_ctl.last;
      p2_ctl.ok      <= p1_ctl.ok;
      p2_ctl.channel <= p1_ctl.channel;
      p2_ctl.idx     <= p1_ctl.idx;
      p2_prod_a      <= prod_a;
      p2_prod_bu     <= prod_bu;
      p2_u           <= p1_u;
      p2_c           <= p1_c;
      p2_d           <= p1_d;
    end
  end

  // floor shift by 16 then add the input term
  assign a_shift = p2_prod_a[DECAY_W+STATE_W:16];
  assign ns_wide = $signed({a_shift[32], a_shift}) + $signed({{2{p2_prod_bu[31]}}, p2_prod_bu});
  assign p2_ns   = sat_state(ns_wide);

  assign state_wr.en   = adv && p2_ctl.valid && p2_ctl.ok;
  assign state_wr.addr = p2_ctl.idx;
  assign state_wr.data = p2_ns;

endmodule

### rtl/core/dss_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_accum
// output products, running sum, skip term and output register
// ----------------------------------------------------------------------------
module dss_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  dss_pkg::item_ctl_t                 p2_ctl,
  input  logic signed [dss_pkg::STATE_W-1:0] p2_ns,
  input  logic signed [dss_pkg::U_W-1:0]     p2_u,
  input  logic signed [dss_pkg::WGT_W-1:0]   p2_c,
  input  logic signed [dss_pkg::WGT_W-1:0]   p2_d,
  output logic                               adv,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dss_pkg::CH_W-1:0]           out_channel,
  output logic signed [dss_pkg::Z_W-1:0]     z_value
);
  import dss_pkg::*;

  item_ctl_t                   p3_ctl;
  logic signed [STATE_W-1:0]   p3_ns;
  logic signed [U_W-1:0]       p3_u;
  logic signed [WGT_W-1:0]     p3_c;
  logic signed [WGT_W-1:0]     p3_d;

  item_ctl_t                   p4_ctl;
  logic signed [47:0]          p4_prod_c;
  logic signed [31:0]          p4_prod_du;

  item_ctl_t                   p5_ctl;
  logic signed [SUM_W-1:0]     p5_sum;
  logic signed [31:0]          p5_prod_du;

  logic signed [SUM_W-1:0]     sum_acc;
  logic signed [SUM_W-1:0]     sum_next;
  logic signed [35:0]          c_shift;
  logic signed [SUM_W:0]       z_wide;

  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_ctl.valid <= 1'b0;
      p4_ctl.valid <= 1'b0;
      p5_ctl.valid <= 1'b0;
    end else if (adv) begin
      p3_ctl.valid <= p2_ctl.valid;
      p4_ctl.valid <= p3_ctl.valid;
      p5_ctl.valid <= p4_ctl.valid;
    end
    if (adv) begin
      p3_ctl.last    <= p2_ctl.last;
      p3_ctl.ok      <= p2_ctl.ok;
      p3_ctl.channel <= p2_ctl.channel;
      p3_ctl.idx     <= p2_ctl.idx;
      p3_ns          <= p2_ns;
      p3_u           <= p2_u;
      p3_c           <= p2_c;
      p3_d           <= p2_d;
      p4_ctl.last    <= p3_ctl.last;
      p4_ctl.ok      <= p3_ctl.ok;
      p4_ctl.channel <= p3_ctl.channel;
      p4_ctl.idx     <= p3_ctl.idx;
      p4_prod_c      <= p3_c * p3_ns;
      p4_prod_du     <= p3_d * p3_u;
      p5_ctl.last    <= p4_ctl.last;
      p5_ctl.ok      <= p4_ctl.ok;
      p5_ctl.channel <= p4_ctl.channel;
      p5_ctl.idx     <= p4_ctl.idx;
      p5_sum         <= sum_next;
      p5_prod_du     <= p4_prod_du;
    end
  end

  // floor shift by 12 into the sum format
  assign c_shift  = p4_prod_c[47:12];
  assign sum_next = sat_sum($signed({sum_acc[SUM_W-1], sum_acc})
                          + $signed({{(SUM_W-35){c_shift[35]}}, c_shift}));

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc <= '0;
    end else if (adv && p4_ctl.valid) begin
      sum_acc <= p4_ctl.last ? '0 : sum_next;
    end
  end

  assign z_wide = $signed({p5_sum[SUM_W-1], p5_sum})
                + $signed({{(SUM_W-31){p5_prod_du[31]}}, p5_prod_du});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p5_ctl.valid && p5_ctl.last;
    end
    if (adv) begin
      out_channel <= p5_ctl.channel;
      z_value     <= sat_z(z_wide);
    end
  end

  // a result only ever comes from an item marked last
  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(p5_ctl.valid) && $past(p5_ctl.last))
    else $error("result without a last item");

  // the sum restarts after every last item
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && p4_ctl.valid && p4_ctl.last) |=> (sum_acc == '0))
    else $error("sum not cleared after last item");

endmodule

### rtl/core/diagonal_ssm_scan_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_ssm_scan_step_top
// diagonal state-space recurrence, one state element per request
// ----------------------------------------------------------------------------
// a channel's result is registered after its last request has passed stages p1 to p5
// throughput: one request per cycle while results are taken; a request that hits
//   the same state element as one of the two before it waits for that write back
// reset: after rst falls the state memory is cleared, one entry a cycle, over all
//   16384 entries (CHANNELS * STATE_SLOTS); ready stays low during that pass
// a full output register that is not taken holds the whole pipeline
module diagonal_ssm_scan_step_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dss_pkg::CH_W-1:0]           channel,
  input  logic [dss_pkg::SLOT_W-1:0]         slot,
  input  logic signed [dss_pkg::U_W-1:0]     u_value,
  input  logic signed [dss_pkg::A_W-1:0]     a_raw,
  input  logic signed [dss_pkg::WGT_W-1:0]   b_weight,
  input  logic signed [dss_pkg::WGT_W-1:0]   c_weight,
  input  logic signed [dss_pkg::WGT_W-1:0]   d_weight,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dss_pkg::CH_W-1:0]           out_channel,
  output logic signed [dss_pkg::Z_W-1:0]     z_value
);
  import dss_pkg::*;

  // clearing pass over the state memory
  logic                  clearing;
  logic [IDX_W-1:0]      clear_idx;

  // request decode
  logic                  in_ok;
  logic [IDX_W-1:0]      in_idx;
  logic                  hazard;
  logic                  accept;
  logic                  adv;

  // first stage: memory and decay data arrive here
  item_ctl_t             p1_ctl;
  logic signed [U_W-1:0] p1_u;
  logic signed [WGT_W-1:0] p1_b;
  logic signed [WGT_W-1:0] p1_c;
  logic signed [WGT_W-1:0] p1_d;
  logic [STATE_W-1:0]    old_raw;
  logic [DECAY_W-1:0]    decay;

  // second stage outputs
  item_ctl_t             p2_ctl;
  logic signed [STATE_W-1:0] p2_ns;
  logic signed [U_W-1:0] p2_u;
  logic signed [WGT_W-1:0] p2_c;
  logic signed [WGT_W-1:0] p2_d;
  state_wr_t             upd_wr;
  state_wr_t             mem_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == IDX_W'(STATE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign in_ok  = (32'(channel) < CHANNELS) && (32'(slot) < STATE_SLOTS);
  assign in_idx = IDX_W'(32'(channel) * STATE_SLOTS + 32'(slot));

  // an element still in flight has not been written back yet
  assign hazard = in_ok &&
                  ((p1_ctl.valid && p1_ctl.ok && (p1_ctl.idx == in_idx)) ||
                   (p2_ctl.valid && p2_ctl.ok && (p2_ctl.idx == in_idx)));

  assign in_ready = !clearing && adv && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_ctl.valid <= 1'b0;
    end else if (adv) begin
      p1_ctl.valid <= accept;
    end
    if (adv && accept) begin
      p1_ctl.last    <= last;
      p1_ctl.ok      <= in_ok;
      p1_ctl.channel <= channel;
      p1_ctl.idx     <= in_idx;
      p1_u           <= u_value;
      p1_b           <= b_weight;
      p1_c           <= c_weight;
      p1_d           <= d_weight;
    end
  end

  // the clearing pass owns the write port until it ends
  always_comb begin
    if (clearing) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clear_idx;
      mem_wr.data = '0;
    end else begin
      mem_wr = upd_wr;
    end
  end

  dss_ram #(
    .WIDTH (STATE_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.data),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (old_raw)
  );

  dss_decay_rom u_decay_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (a_raw),
    .rd_data (decay)
  );

  dss_state_update u_update (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .p1_ctl   (p1_ctl),
    .old_raw  (old_raw),
    .decay    (decay),
    .p1_u     (p1_u),
    .p1_b     (p1_b),
    .p1_c     (p1_c),
    .p1_d     (p1_d),
    .p2_ctl   (p2_ctl),
    .p2_ns    (p2_ns),
    .p2_u     (p2_u),
    .p2_c     (p2_c),
    .p2_d     (p2_d),
    .state_wr (upd_wr)
  );

  dss_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .p2_ctl      (p2_ctl),
    .p2_ns       (p2_ns),
    .p2_u        (p2_u),
    .p2_c        (p2_c),
    .p2_d        (p2_d),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .z_value     (z_value)
  );

  // no request is taken while the memory is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request taken during clearing pass");

  // a fresh read never lands on the entry being written back
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ok && mem_wr.en) |-> (mem_wr.addr != in_idx))
    else $error("read of an element under write back");

  // a held pipeline keeps the first stage untouched
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(p1_ctl))
    else $error("first stage changed during stall");

endmodule

### bench/diagonal_ssm_scan_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_ssm_scan_step_checker
// watches both channels, keeps its own copy of the state rows, the running
// sum and the decay table, and checks every z result against the oldest
// outstanding prediction
// ----------------------------------------------------------------------------
module diagonal_ssm_scan_step_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [dss_pkg::CH_W-1:0]         channel,
  input  logic [dss_pkg::SLOT_W-1:0]       slot,
  input  logic signed [dss_pkg::U_W-1:0]   u_value,
  input  logic signed [dss_pkg::A_W-1:0]   a_raw,
  input  logic signed [dss_pkg::WGT_W-1:0] b_weight,
  input  logic signed [dss_pkg::WGT_W-1:0] c_weight,
  input  logic signed [dss_pkg::WGT_W-1:0] d_weight,
  input  logic                             last,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [dss_pkg::CH_W-1:0]         out_channel,
  input  logic signed [dss_pkg::Z_W-1:0]   z_value,
  output int                               mismatches,
  output int                               pending
);
  import dss_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CH_W-1:0]       channel;
    logic signed [Z_W-1:0] z;
  } z_result_t;

  logic [DECAY_W-1:0]        sigmoid_rom [DECAY_DEPTH];
  logic signed [STATE_W-1:0] elem_state [STATE_DEPTH];
  longint                    run_sum;
  z_result_t                 z_queue [$];

  // exact sigmoid table in q0.16, built with 62-bit fixed point exp series
  function automatic void fill_sigmoid_rom();
    logic [63:0]  term;
    logic [63:0]  q;
    logic [63:0]  e;
    logic [63:0]  dp;
    logic [63:0]  ep;
    logic [63:0]  r;
    logic [127:0] prod;
    term = 64'd1 << 62;
    q    = term;
    e    = term;
    for (int k = 1; k <= 10; k++) begin
      term = term / (64'd256 * k);
      if (k % 2 == 1) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (int m = 0; m <= 2048; m++) begin
      dp = ((64'd1 << 62) + e) >> 16;
      if (m <= 2047) begin
        r = ((64'd1 << 63) + dp) / (64'd2 * dp);
        sigmoid_rom[m] = (r > 64'd65535) ? 16'hffff : r[15:0];
      end
      if (m >= 1) begin
        ep = e >> 16;
        r  = ((ep << 17) + dp) / (64'd2 * dp);
        sigmoid_rom[DECAY_DEPTH - m] = (r > 64'd65535) ? 16'hffff : r[15:0];
      end
      prod = {64'd0, e} * {64'd0, q};
      e    = prod[125:62];
    end
  endfunction

  function automatic longint clamp_signed(input longint x, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      return hi;
    end
    if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // one state element update; returns 1 when the request closes a channel
  function automatic bit step_element(
    input  logic [CH_W-1:0]         ch,
    input  logic [SLOT_W-1:0]       sl,
    input  logic signed [U_W-1:0]   u,
    input  logic [A_W-1:0]          ar,
    input  logic signed [WGT_W-1:0] b,
    input  logic signed [WGT_W-1:0] c,
    input  logic signed [WGT_W-1:0] d,
    input  logic                    lst,
    output z_result_t               res
  );
    bit     in_range;
    int     idx;
    longint decay;
    longint prev;
    longint next_state;
    longint z;
    in_range   = (int'(ch) < CHANNELS) && (int'(sl) < STATE_SLOTS);
    idx        = int'(ch) * STATE_SLOTS + int'(sl);
    decay      = longint'(sigmoid_rom[ar]);
    prev       = in_range ? longint'(elem_state[idx]) : 0;
    next_state = clamp_signed(((decay * prev) >>> 16) + longint'(b) * longint'(u), STATE_W);
    if (in_range) begin
      elem_state[idx] = next_state[STATE_W-1:0];
    end
    run_sum = clamp_signed(run_sum + ((longint'(c) * next_state) >>> 12), SUM_W);
    res = '0;
    if (!lst) begin
      return 1'b0;
    end
    z           = clamp_signed(run_sum + longint'(d) * longint'(u), Z_W);
    run_sum     = 0;
    res.channel = ch;
    res.z       = z[Z_W-1:0];
    return 1'b1;
  endfunction

  initial begin
    fill_sigmoid_rom();
  end

  always @(posedge clk) begin : watch
    z_result_t got;
    z_result_t want;
    z_result_t made;
    if (rst) begin
      run_sum    = 0;
      mismatches = 0;
      for (int i = 0; i < STATE_DEPTH; i++) begin
        elem_state[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        got.channel = out_channel;
        got.z       = z_value;
        if (z_queue.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t unexpected result: channel %0d z %0d", $time, got.channel, got.z);
          end
          mismatches++;
        end else begin
          want = z_queue.pop_front();
          if (got.channel !== want.channel || got.z !== want.z) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t result mismatch: channel exp %0d got %0d, z exp %0d got %0d",
                       $time, want.channel, got.channel, want.z, got.z);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (step_element(channel, slot, u_value, a_raw, b_weight, c_weight, d_weight,
                         last, made)) begin
          z_queue.push_back(made);
        end
      end
    end
    pending = z_queue.size();
  end

endmodule

### bench/diagonal_ssm_scan_step_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_ssm_scan_step_top_test
// drives state-element requests into the scan step and gives the verdict;
// a directed set, two runs that pin the z output to its rails, then
// random channel rows with bursty requests and a stalling result side
// ----------------------------------------------------------------------------
module diagonal_ssm_scan_step_top_test;
  import dss_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 300;
  localparam int RAIL_ITEMS   = 48;     // at most ~2^34 each, z leaves 40 bits by 40
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int HOLD_AT      = 120;    // random request count that triggers it
  localparam int DRAIN_CYCLES = 16;     // margin past the pipeline latency for strays
  localparam int STALL_LIMIT  = 70000;  // covers the clearing pass over 16384 entries

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every input starts at a known value
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [CH_W-1:0]         channel   = '0;
  logic [SLOT_W-1:0]       slot      = '0;
  logic signed [U_W-1:0]   u_value   = '0;
  logic signed [A_W-1:0]   a_raw     = '0;
  logic signed [WGT_W-1:0] b_weight  = '0;
  logic signed [WGT_W-1:0] c_weight  = '0;
  logic signed [WGT_W-1:0] d_weight  = '0;
  logic                    last      = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CH_W-1:0]         out_channel;
  logic signed [Z_W-1:0]   z_value;

  int mismatches;
  int pending;
  int burst_left  = 0;
  int random_sent = 0;
  bit hold_req    = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  diagonal_ssm_scan_step_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .channel     (channel),
    .slot        (slot),
    .u_value     (u_value),
    .a_raw       (a_raw),
    .b_weight    (b_weight),
    .c_weight    (c_weight),
    .d_weight    (d_weight),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .z_value     (z_value)
  );

  diagonal_ssm_scan_step_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .channel     (channel),
    .slot        (slot),
    .u_value     (u_value),
    .a_raw       (a_raw),
    .b_weight    (b_weight),
    .c_weight    (c_weight),
    .d_weight    (d_weight),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .z_value     (z_value),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // q4.12 operand, biased toward the extremes and zero
  function automatic logic signed [WGT_W-1:0] pick_q412();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return WGT_W'($urandom_range(0, 4096));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  // decay input; mostly near one so state carries over between visits
  function automatic logic signed [A_W-1:0] pick_decay();
    case ($urandom_range(0, 7))
      0: return 12'sh7ff;
      1: return 12'sh800;
      2: return '0;
      3, 4: return A_W'($urandom_range(1024, 2047));
      default: return A_W'($urandom);
    endcase
  endfunction

  // a few hot channels so rows are revisited, plus the whole range
  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return CH_W'($urandom_range(1, 6));
      default: return CH_W'($urandom);
    endcase
  endfunction

  // one request; the sender works in bursts with random gaps between them
  task automatic offer(
    input logic [CH_W-1:0]         ch,
    input logic [SLOT_W-1:0]       sl,
    input logic signed [U_W-1:0]   u,
    input logic signed [A_W-1:0]   ar,
    input logic signed [WGT_W-1:0] b,
    input logic signed [WGT_W-1:0] c,
    input logic signed [WGT_W-1:0] d,
    input logic                    lst
  );
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    channel  = ch;
    slot     = sl;
    u_value  = u;
    a_raw    = ar;
    b_weight = b;
    c_weight = c;
    d_weight = d;
    last     = lst;
    in_valid = 1'b1;
    // hold the request until the block takes it
    do @(posedge clk); while (!in_ready);
  endtask

  // same element set of channel 7 over and over: the states saturate and the
  // shared sum runs past the 40-bit output range, then a last request closes it
  task automatic push_z_to_rail(input logic signed [WGT_W-1:0] c);
    for (int i = 0; i < RAIL_ITEMS; i++) begin
      offer(CH_W'(7), SLOT_W'(i), 16'sh8000, 12'sh7ff, 16'sh8000, c, pick_q412(), 1'b0);
    end
    offer(CH_W'(7), '0, 16'sh8000, 12'sh7ff, 16'sh8000, c, 16'sh8000, 1'b1);
  endtask

  // one channel row; now and then slots are scrambled (back-to-back hits on
  // the same element) or the last mark is dropped so rows run together
  task automatic send_row();
    logic [CH_W-1:0]         ch;
    logic signed [U_W-1:0]   u;
    logic signed [WGT_W-1:0] d;
    logic [SLOT_W-1:0]       sl;
    int                      len;
    bit                      scramble;
    bit                      drop_last;
    ch        = pick_channel();
    u         = pick_q412();
    d         = pick_q412();
    len       = ($urandom_range(0, 4) == 0) ? STATE_SLOTS : $urandom_range(1, STATE_SLOTS);
    scramble  = ($urandom_range(0, 4) == 0);
    drop_last = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      sl = scramble ? SLOT_W'($urandom) : SLOT_W'(k);
      offer(ch, sl, u, pick_decay(), pick_q412(), pick_q412(), d,
            (k == len - 1) && !drop_last);
      random_sent++;
      if (random_sent == HOLD_AT) begin
        hold_req = 1'b1;
      end
    end
  endtask

  // result side: its own stall pattern plus one long hold-off
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    bit       held;
    mode      = RX_OPEN;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        // sender keeps offering meanwhile, so the pipeline backs up
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   out_ready = 1'b1;
        RX_COIN:   out_ready = $urandom_range(0, 1);
        RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
        default:   out_ready = 1'b1;
      endcase
    end
  end

  // ends the run if nothing moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // all zero request closes channel 0 with z of zero
    offer('0, '0, '0, '0, '0, '0, '0, 1'b1);
    // top channel and slot, all weights at the positive limit
    offer('1, '1, 16'sh7fff, 12'sh7ff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    // same element again right away: decay near one brings the state near its rail
    offer('1, '1, 16'sh7fff, 12'sh7ff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    // repeated element with negative input, state goes to the negative rail
    offer(CH_W'(5), SLOT_W'(3), 16'sh8000, 12'sh7ff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
    offer(CH_W'(5), SLOT_W'(3), 16'sh8000, 12'sh7ff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
    offer(CH_W'(5), SLOT_W'(3), 16'sh8000, 12'sh7ff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1);
    // most negative decay input wipes nearly all of the stored state
    offer(CH_W'(5), SLOT_W'(3), '0, 12'sh800, '0, 16'sh7fff, 16'sh7fff, 1'b1);
    // mixed channels share one sum, the result names the closing channel
    offer(CH_W'(6), SLOT_W'(0), 16'sh8000, '0, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
    offer(CH_W'(6), SLOT_W'(1), 16'sh8000, '0, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
    offer(CH_W'(512), SLOT_W'(8), 16'sh8000, 12'sh001, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
    // decay just below one half on a revisited element
    offer(CH_W'(6), SLOT_W'(0), 16'sh1000, 12'shfff, 16'sh1000, 16'sh1000, 16'sh1000, 1'b1);
    // skip path alone
    offer(CH_W'(300), SLOT_W'(0), 16'sh7fff, 12'sh400, '0, '0, 16'sh8000, 1'b1);
    // alternating bit patterns on every field
    offer(CH_W'(10'h2aa), SLOT_W'(4'ha), 16'sh5555, 12'sh555, 16'shaaaa, 16'sh5555,
          16'shaaaa, 1'b0);
    offer(CH_W'(10'h155), SLOT_W'(4'h5), 16'shaaaa, 12'shaaa, 16'sh5555, 16'shaaaa,
          16'sh5555, 1'b1);

    // rows closed only at the end: z saturates low, then high
    push_z_to_rail(16'sh8000);
    push_z_to_rail(16'sh7fff);

    // random part: mostly well-formed rows, some stray single requests
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(CH_W'($urandom), SLOT_W'($urandom), pick_q412(), pick_decay(), pick_q412(),
              pick_q412(), pick_q412(), 1'($urandom));
        random_sent++;
      end else begin
        send_row();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    // wait for every predicted result, then a little longer for strays
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
